@@ hdl/skdr_pkg.sv @@
// Shared types and constants for the keyed-removal stack.
`default_nettype none
package skdr_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned KeyW         = 31;
  localparam int unsigned MovesW       = 5;
  localparam int unsigned InDataW      = 32;
  localparam int unsigned OutDataW     = 8;

  typedef enum logic {
    REQ_PUSH   = 1'b0,
    REQ_REMOVE = 1'b1
  } skdr_req_e;

  typedef enum logic {
    STS_OK   = 1'b0,
    STS_FULL = 1'b1
  } skdr_status_e;

  // Handed from a cell to the cell below it.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            hit;
  } skdr_down_t;

  // Handed from a cell to the cell above it.
  typedef struct packed {
    logic valid;
    logic shift;
  } skdr_up_t;

  // Request broadcast to every cell.
  typedef struct packed {
    logic            en;
    skdr_req_e       req;
    logic [KeyW-1:0] key;
  } skdr_cmd_t;

endpackage
`default_nettype wire

@@ hdl/skdr_cell.sv @@
// One stack slot: holds a key, compares it and shifts or loads on a request.
`default_nettype none
module skdr_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  skdr_pkg::skdr_cmd_t  cmd_i,
  input  skdr_pkg::skdr_down_t down_i,
  input  skdr_pkg::skdr_up_t   up_i,
  output skdr_pkg::skdr_down_t down_o,
  output skdr_pkg::skdr_up_t   up_o,
  output logic                 first_o
);
  import skdr_pkg::*;

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            match;
  logic            shift_here;

  // The topmost match is the one with no match above it.
  assign match      = valid_q && (key_q == cmd_i.key);
  assign first_o    = match && !down_i.hit;
  assign shift_here = up_i.shift || first_o;

  assign down_o = '{valid: valid_q, key: key_q, hit: down_i.hit || match};
  assign up_o   = '{valid: valid_q, shift: shift_here};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.en) begin
      if (cmd_i.req == REQ_PUSH) begin
        if (!valid_q && up_i.valid) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
        end
      end else if (shift_here && valid_q) begin
        valid_d = down_i.valid;
        key_d   = down_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
`default_nettype wire

@@ hdl/stack_keyed_removal_depth_unit.sv @@
// Top level of the bounded key stack with push and keyed removal.
// Usage:
//   Requests arrive as beats on the s_axis channel, each with a request kind and a
//   31-bit key. A push puts the key on top of the stack; a remove searches from the top
//   and takes out the topmost matching entry, with the entries above it closing the gap.
//   Every request gives exactly one result beat on m_axis: a status bit and a move count.
// Latency and throughput:
//   A registered result appears in the cycle after its request is accepted. The stack is
//   a row of DEPTH slot cells; every cell compares its key in parallel, the
//   topmost-match flag ripples down the row and the shift enable ripples up
//   it, so the whole update completes in the accepting cycle. One request
//   is accepted every cycle while results are taken.
// Reset:
//   Reset empties the stack (all cell valid bits and the occupancy count
//   clear) and drops any pending result. Slot keys are not reset.
// Stalls:
//   A single output register holds the result. While it is full and the
//   receiver holds m_axis_tready_i low, s_axis_tready_o is low; when the
//   receiver takes the result, a new request can be accepted in the same
//   cycle.
`default_nettype none
module stack_keyed_removal_depth_unit #(
  parameter int unsigned DEPTH = skdr_pkg::DefaultDepth
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: req_type[0], key[31:1].
  input  wire  [skdr_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // Fields from bit 0: status[0], moves[5:1], zero padding[7:6].
  output logic [skdr_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import skdr_pkg::*;

  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  skdr_cmd_t            cmd;
  skdr_down_t           down_link [DEPTH+1];
  skdr_up_t             up_link   [DEPTH+1];
  logic [DEPTH-1:0]     first;
  logic [DEPTH-1:0]     cell_valid;
  logic                 accept;
  logic                 found;
  logic [IdxW-1:0]      pos;
  logic [OccW-1:0]      occ_q, occ_d;
  logic                 out_valid_q;
  logic                 status_q, status_d;
  logic [MovesW-1:0]    moves_q, moves_d;
  logic [OccW-1:0]      diff;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd = '{en:  accept,
                 req: skdr_req_e'(s_axis_tdata_i[0]),
                 key: s_axis_tdata_i[KeyW:1]};

  // The top end sees no match and no entry above; the bottom end sees a
  // filled slot below so that an empty stack loads into cell zero.
  assign down_link[DEPTH] = '{valid: 1'b0, key: '0, hit: 1'b0};
  assign up_link[0]       = '{valid: 1'b1, shift: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skdr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .down_i  (down_link[i+1]),
      .up_i    (up_link[i]),
      .down_o  (down_link[i]),
      .up_o    (up_link[i+1]),
      .first_o (first[i])
    );
    assign cell_valid[i] = down_link[i].valid;
  end

  assign found = down_link[0].hit;

  // At most one cell raises first, so an OR of the masked indexes gives it.
  always_comb begin
    pos = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | IdxW'(i);
      end
    end
  end

  assign diff = occ_q - OccW'(pos);

  always_comb begin
    occ_d    = occ_q;
    status_d = STS_OK;
    moves_d  = '0;
    if (cmd.req == REQ_PUSH) begin
      if (occ_q == OccW'(DEPTH)) begin
        status_d = STS_FULL;
      end else begin
        occ_d   = occ_q + OccW'(1);
        moves_d = MovesW'(1);
      end
    end else if (found) begin
      occ_d   = occ_q - OccW'(1);
      moves_d = MovesW'(diff);
    end else begin
      moves_d = MovesW'(occ_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      moves_q  <= moves_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - MovesW - 1){1'b0}}, moves_q, status_q};

  // The cell valid bits always describe exactly the counted entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(occ_q))
    else $error("cell valid bits disagree with occupancy");

  // Occupied cells form a solid run from the bottom.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & (cell_valid + DEPTH'(1))) == '0))
    else $error("gap in occupied cells");

  // A successful push grows the stack by one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.req == REQ_PUSH && occ_q != OccW'(DEPTH))
    |=> (occ_q == $past(occ_q) + OccW'(1)))
    else $error("push did not grow the stack");

endmodule
`default_nettype wire

@@ tb/stack_keyed_removal_depth_unit_test.sv @@
// Self-checking testbench for the keyed-removal stack: directed table, then random traffic.
`default_nettype none
module stack_keyed_removal_depth_unit_test;
  import skdr_pkg::*;

  localparam int unsigned RandomRequests = 1330;
  localparam int unsigned StallLimit     = 5000;

  // Expected result of one request, in the order the fields leave the block.
  typedef struct packed {
    skdr_status_e      status;
    logic [MovesW-1:0] moves;
  } result_t;

  // One row of the directed table. A row may repeat its request, and may carry a
  // hand-written result that replaces the predicted one.
  typedef struct {
    skdr_req_e         req;
    logic [KeyW-1:0]   key;
    int unsigned       reps;
    bit                typed;
    skdr_status_e      want_status;
    logic [MovesW-1:0] want_moves;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tready = 1'b0;
  logic                steady = 1'b0;
  wire                 s_axis_tready_o;
  wire                 m_axis_tvalid_o;
  wire [OutDataW-1:0]  m_axis_tdata_o;

  // Mirror of the stack contents, bottom at index 0.
  logic [KeyW-1:0]     mirror_keys [DefaultDepth];
  int                  mirror_count = 0;
  result_t             pending_results [$];
  result_t             oldest;

  int unsigned         mismatches = 0;
  int unsigned         push_count = 0;
  int unsigned         full_count = 0;
  int unsigned         hit_count = 0;
  int unsigned         miss_count = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         max_moves_seen = 0;

  plan_row_t           plan [10];
  logic [KeyW-1:0]     key_pool [8];

  stack_keyed_removal_depth_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int unsigned expected,
                                 input int unsigned actual);
    $display("MISMATCH %s: expected %0d, got %0d", what, expected, actual);
    mismatches++;
  endtask

  // Applies one request to the mirror and returns the result it must produce.
  function automatic result_t stack_apply(input skdr_req_e req, input logic [KeyW-1:0] key);
    result_t r;
    int      hit_at;
    int      d;
    r.status = STS_OK;
    r.moves  = '0;
    hit_at   = -1;
    if (req == REQ_PUSH) begin
      push_count++;
      if (mirror_count >= DefaultDepth) begin
        r.status = STS_FULL;
        full_count++;
      end else begin
        mirror_keys[mirror_count] = key;
        mirror_count++;
        r.moves = MovesW'(1);
      end
    end else begin
      // Search from the top so that only the topmost duplicate is taken out.
      for (d = mirror_count - 1; d >= 0 && hit_at < 0; d--) begin
        if (mirror_keys[d] == key) hit_at = d;
      end
      if (hit_at >= 0) begin
        r.moves = MovesW'(mirror_count - hit_at);
        for (d = hit_at; d < mirror_count - 1; d++) mirror_keys[d] = mirror_keys[d + 1];
        mirror_count--;
        hit_count++;
      end else begin
        r.moves = MovesW'(mirror_count);
        miss_count++;
      end
    end
    return r;
  endfunction

  // Offers one request beat, with random idle cycles ahead of it, and books the
  // expected result once the beat is taken.
  task automatic send_request(input skdr_req_e req, input logic [KeyW-1:0] key,
                              input bit typed, input skdr_status_e want_status,
                              input logic [MovesW-1:0] want_moves);
    result_t predicted;
    while (!steady && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= {key, req};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = stack_apply(req, key);
    if (typed) pending_results.push_back('{want_status, want_moves});
    else pending_results.push_back(predicted);
  endtask

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    m_tready <= steady || ($urandom_range(99) >= 27);
  end

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, m_axis_tdata_o);
      end else begin
        oldest = pending_results.pop_front();
        if (m_axis_tdata_o[0] !== oldest.status)
          report_mismatch("status", oldest.status, m_axis_tdata_o[0]);
        if (m_axis_tdata_o[MovesW:1] !== oldest.moves)
          report_mismatch("moves", oldest.moves, m_axis_tdata_o[MovesW:1]);
        if (m_axis_tdata_o[OutDataW-1:MovesW+1] !== '0)
          report_mismatch("padding", 0, m_axis_tdata_o[OutDataW-1:MovesW+1]);
        if (int'(oldest.moves) > max_moves_seen) max_moves_seen = int'(oldest.moves);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no beat accepted for %0d cycles", StallLimit);
          $display("stack_keyed_removal_depth_unit verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned     n;
    int unsigned     r;
    int unsigned     push_bias;
    int unsigned     phase_left;
    skdr_req_e       req;
    logic [KeyW-1:0] key;

    // Directed part: empty, fill to full, refused push, bottom removal from a full
    // stack, topmost duplicate, miss on a non-empty stack, then the largest key.
    plan[0] = '{REQ_REMOVE, 31'h0000_0000, 1,  1'b1, STS_OK,   5'd0};
    plan[1] = '{REQ_PUSH,   31'h0000_0000, 1,  1'b1, STS_OK,   5'd1};
    plan[2] = '{REQ_PUSH,   31'h7FFF_FFFF, 1,  1'b0, STS_OK,   5'd0};
    plan[3] = '{REQ_PUSH,   31'h1555_5555, 13, 1'b0, STS_OK,   5'd0};
    plan[4] = '{REQ_PUSH,   31'h2AAA_AAAA, 1,  1'b0, STS_OK,   5'd0};
    plan[5] = '{REQ_PUSH,   31'h0000_0001, 1,  1'b1, STS_FULL, 5'd0};
    plan[6] = '{REQ_REMOVE, 31'h0000_0000, 1,  1'b1, STS_OK,   5'd16};
    plan[7] = '{REQ_REMOVE, 31'h1555_5555, 1,  1'b0, STS_OK,   5'd0};
    plan[8] = '{REQ_REMOVE, 31'h0000_0003, 1,  1'b0, STS_OK,   5'd0};
    plan[9] = '{REQ_REMOVE, 31'h7FFF_FFFF, 1,  1'b0, STS_OK,   5'd0};

    // A small key pool makes removes hit often; the edge keys stay in it.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (n = 2; n < 8; n++) key_pool[n] = KeyW'($urandom);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (n = 0; n < plan[i].reps; n++)
        send_request(plan[i].req, plan[i].key, plan[i].typed,
                     plan[i].want_status, plan[i].want_moves);
    end

    // Random part. The push share changes from phase to phase so that the stack
    // swings between empty and full.
    push_bias  = 50;
    phase_left = 0;
    for (n = 0; n < RandomRequests; n++) begin
      if (phase_left == 0) begin
        r = $urandom_range(2);
        push_bias  = (r == 0) ? 80 : (r == 1) ? 25 : 55;
        phase_left = $urandom_range(80, 40);
      end
      phase_left--;
      steady <= (n >= 300 && n < 600);
      if (n == 700) begin
        // Hold off until the block has returned every result.
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      req = ($urandom_range(99) < push_bias) ? REQ_PUSH : REQ_REMOVE;
      r   = $urandom_range(99);
      if (r < 60) key = key_pool[$urandom_range(7)];
      else if (r < 75 && mirror_count > 0) key = mirror_keys[$urandom_range(mirror_count - 1)];
      else key = KeyW'($urandom);
      send_request(req, key, 1'b0, STS_OK, '0);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d pushes (%0d refused on a full stack) and %0d removes",
             push_count, full_count, hit_count + miss_count);
    $display("Removes: %0d found the key, %0d missed; largest move count seen %0d",
             hit_count, miss_count, max_moves_seen);
    if (mismatches == 0) begin
      $display("stack_keyed_removal_depth_unit verification clean");
    end else begin
      $display("stack_keyed_removal_depth_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
